// File: rtl/pms_pkg.sv
// Package for the partitioned multi-stack block.
// Holds the sizing constants, the item and result word types, codes and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package pms_pkg;

    // Storage sizing.
    localparam int STORE_DEPTH = 1024;
    localparam int MAX_STACKS  = 8;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SIZE_W      = $clog2(STORE_DEPTH + 1);
    localparam int STACK_W     = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int CNTE_W      = $clog2(MAX_STACKS + 1);
    localparam int STEP_W      = $clog2(SIZE_W + 1);

    // Fixed field widths.
    localparam int USED_W      = 11;
    localparam int COUNT_W     = 4;
    localparam int IDX_W       = 3;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = USED_W;

    typedef enum logic [0:0] {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USED_SIZE   = 2'd0,
        CFG_STACK_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SETUP_LOAD,
        SETUP_DIV,
        SETUP_SWEEP,
        SETUP_IDLE
    } setup_state_t;

    typedef struct packed {
        action_t                   action;
        logic [IDX_W-1:0]          stack_index;
        logic signed [DATA_W-1:0]  item_value;
    } item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  popped_value;
    } result_t;

    // One entry per stack: region base or region capacity.
    typedef logic [MAX_STACKS-1:0][SIZE_W-1:0] region_tab_t;

    // Partition state handed from the setup unit to the stack engine.
    typedef struct packed {
        logic              ready;
        logic [CNTE_W-1:0] count_eff;
    } layout_t;

    // Word store access request.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

endpackage

// File: rtl/pms_word_ram.sv
// Single-port word store with a registered read port.
// Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_word_ram (
    input  logic                         clk,
    input  pms_pkg::mem_req_t            req,
    output logic [pms_pkg::DATA_W-1:0]   rd_data
);
    import pms_pkg::*;

    logic [DATA_W-1:0] mem [STORE_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/pms_setup.sv
// Configuration registers and partition setup: a serial divider for the region
// length followed by a sweep that fills the per-stack base and capacity tables.
// Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_setup (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pms_pkg::CFG_W-1:0]      cfg_data,
    output pms_pkg::layout_t               layout,
    output pms_pkg::region_tab_t           base_tab,
    output pms_pkg::region_tab_t           cap_tab
);
    import pms_pkg::*;

    setup_state_t       state_reg, state_next;
    logic [USED_W-1:0]  used_reg;
    logic [COUNT_W-1:0] scount_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [STACK_W-1:0] slot_reg;
    logic [SIZE_W-1:0]  quo_reg;
    logic [CNTE_W-1:0]  rem_reg;
    logic [SIZE_W-1:0]  acc_reg;
    region_tab_t        base_reg;
    region_tab_t        cap_reg;

    logic [SIZE_W-1:0]  eff_size;
    logic [CNTE_W-1:0]  count_eff;
    logic [CNTE_W:0]    trial;
    logic               fits;
    logic [CNTE_W-1:0]  rem_step;
    logic               last_slot;
    logic               cfg_write;
    logic               cfg_known;
    logic               load_en, div_en, sweep_en, idle;

    always_comb
    begin
        if (used_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(used_reg) > STORE_DEPTH)
        begin
            eff_size = SIZE_W'(STORE_DEPTH);
        end
        else
        begin
            eff_size = SIZE_W'(used_reg);
        end

        if (scount_reg == '0)
        begin
            count_eff = CNTE_W'(1);
        end
        else if (32'(scount_reg) > MAX_STACKS)
        begin
            count_eff = CNTE_W'(MAX_STACKS);
        end
        else
        begin
            count_eff = CNTE_W'(scount_reg);
        end
    end

    // One restoring division step per cycle.
    assign trial    = {rem_reg, quo_reg[SIZE_W-1]};
    assign fits     = trial >= {1'b0, count_eff};
    assign rem_step = fits ? CNTE_W'(trial - {1'b0, count_eff}) : trial[CNTE_W-1:0];

    assign last_slot = ({1'b0, slot_reg} + 1'b1) == (STACK_W + 1)'(count_eff);
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == CFG_USED_SIZE) || (cfg_index == CFG_STACK_COUNT);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SETUP_LOAD:
            begin
                state_next = SETUP_DIV;
            end
            SETUP_DIV:
            begin
                if (step_reg == STEP_W'(SIZE_W - 1))
                begin
                    state_next = SETUP_SWEEP;
                end
            end
            SETUP_SWEEP:
            begin
                if (slot_reg == STACK_W'(MAX_STACKS - 1))
                begin
                    state_next = SETUP_IDLE;
                end
            end
            SETUP_IDLE:
            begin
                if (cfg_write && cfg_known)
                begin
                    state_next = SETUP_LOAD;
                end
            end
            default:
            begin
                state_next = SETUP_LOAD;
            end
        endcase
    end

    always_comb
    begin
        load_en  = 1'b0;
        div_en   = 1'b0;
        sweep_en = 1'b0;
        idle     = 1'b0;
        case (state_reg)
            SETUP_LOAD:  load_en  = 1'b1;
            SETUP_DIV:   div_en   = 1'b1;
            SETUP_SWEEP: sweep_en = 1'b1;
            SETUP_IDLE:  idle     = 1'b1;
            default:     load_en  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SETUP_LOAD;
            used_reg   <= USED_W'(1024);
            scount_reg <= COUNT_W'(1);
            step_reg   <= '0;
            slot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && (cfg_index == CFG_USED_SIZE))
            begin
                used_reg <= cfg_data[USED_W-1:0];
            end
            if (cfg_write && (cfg_index == CFG_STACK_COUNT))
            begin
                scount_reg <= cfg_data[COUNT_W-1:0];
            end
            if (load_en)
            begin
                step_reg <= '0;
                slot_reg <= '0;
            end
            if (div_en)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (sweep_en)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            quo_reg <= eff_size;
            rem_reg <= '0;
            acc_reg <= '0;
        end
        if (div_en)
        begin
            quo_reg <= {quo_reg[SIZE_W-2:0], fits};
            rem_reg <= rem_step;
        end
        if (sweep_en)
        begin
            base_reg[slot_reg] <= acc_reg;
            cap_reg[slot_reg]  <= last_slot ? (eff_size - acc_reg) : quo_reg;
            acc_reg            <= acc_reg + quo_reg;
        end
    end

    assign cfg_ready        = idle;
    assign layout.ready     = idle;
    assign layout.count_eff = count_eff;
    assign base_tab         = base_reg;
    assign cap_tab          = cap_reg;

endmodule

// File: rtl/pms_engine.sv
// Stack engine: fill counts, status decision, store access and the result pipeline.
// Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  pms_pkg::item_t               in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output pms_pkg::result_t             out_data,
    input  pms_pkg::layout_t             layout,
    input  pms_pkg::region_tab_t         base_tab,
    input  pms_pkg::region_tab_t         cap_tab,
    output pms_pkg::mem_req_t            mem_req,
    input  logic [pms_pkg::DATA_W-1:0]   rd_data
);
    import pms_pkg::*;

    logic [MAX_STACKS-1:0][SIZE_W-1:0] fill_reg;
    logic               s1_valid_reg;
    status_t            s1_status_reg;
    logic               s1_pop_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;

    logic               out_free, s1_adv, accept;
    logic [STACK_W-1:0] slot;
    logic [SIZE_W-1:0]  fill, base, cap, ptr;
    logic               bad, is_pop;
    status_t            status;
    logic               op_ok;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = !layout.ready || (s1_valid_reg && !out_free);
    assign accept   = in_valid && !in_stall;

    assign slot   = in_data.stack_index[STACK_W-1:0];
    assign fill   = fill_reg[slot];
    assign base   = base_tab[slot];
    assign cap    = cap_tab[slot];
    assign ptr    = base + fill;
    assign is_pop = (in_data.action == ACT_POP);
    assign bad    = 32'(in_data.stack_index) >= 32'(layout.count_eff);

    always_comb
    begin
        if (bad)
        begin
            status = ST_BAD_INDEX;
        end
        else if (!is_pop && (fill >= cap))
        begin
            status = ST_OVERFLOW;
        end
        else if (is_pop && (fill == '0))
        begin
            status = ST_UNDERFLOW;
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign op_ok = accept && (status == ST_OK);

    always_comb
    begin
        mem_req.wr_en   = op_ok && !is_pop;
        mem_req.rd_en   = op_ok && is_pop;
        mem_req.addr    = is_pop ? ADDR_W'(ptr - 1'b1) : ptr[ADDR_W-1:0];
        mem_req.wr_data = in_data.item_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!layout.ready)
            begin
                fill_reg <= '0;
            end
            else if (op_ok)
            begin
                fill_reg[slot] <= is_pop ? (fill - 1'b1) : (fill + 1'b1);
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
            s1_pop_reg    <= is_pop;
        end
        if (s1_adv)
        begin
            out_data_reg.status       <= s1_status_reg;
            out_data_reg.popped_value <= (s1_pop_reg && (s1_status_reg == ST_OK)) ?
                                         rd_data : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/partitioned_multi_stack.sv
// Partitioned multi-stack: several stacks share one word store in fixed regions.
// Each accepted item word is registered in the s1 stage, then its result word in the output register.
// Throughput: one item word per cycle while in_stall is low, set by the single store port (push writes, pop reads).
// Reset, and every write to a known register, starts a setup (11-step divider,
// then an 8-step region sweep) with in_stall high and cfg_ready low; all stacks start empty.
// Depends on pms_pkg, pms_setup, pms_engine and pms_word_ram.
`timescale 1ns / 1ps

module partitioned_multi_stack (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pms_pkg::item_t                 in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pms_pkg::result_t               out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pms_pkg::CFG_W-1:0]      cfg_data
);
    import pms_pkg::*;

    // The setup unit owns the two configuration registers. It works out the
    // region length by serial division, then sweeps the stacks once to record
    // each region's base and capacity. While it runs, the engine holds every
    // fill count at zero, which is what empties all stacks on a re-partition.
    layout_t           layout;
    region_tab_t       base_tab;
    region_tab_t       cap_tab;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;

    pms_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .layout    (layout),
        .base_tab  (base_tab),
        .cap_tab   (cap_tab)
    );

    // The engine keeps a fill count per stack in flip-flops and updates it in
    // the cycle the item is accepted, so the next item on the same stack sees
    // the new count at once. A push writes the store in that cycle; a pop
    // reads it, and the store's read register holds the word until the
    // result is formed. A pop that follows a push to the same word therefore
    // reads the freshly written word without any bypass.
    pms_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .layout    (layout),
        .base_tab  (base_tab),
        .cap_tab   (cap_tab),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    pms_word_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

// File: rtl/pms_checker.sv
// Port-level checker for the partitioned multi-stack, bound to the top level.
// Depends on pms_pkg and partitioned_multi_stack.
`timescale 1ns / 1ps

module pms_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  pms_pkg::result_t               out_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [pms_pkg::CFG_IDX_W-1:0]  cfg_index
);
    import pms_pkg::*;

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    // A write to a known register starts a setup that blocks items.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == CFG_USED_SIZE || cfg_index == CFG_STACK_COUNT)
        |=> !cfg_ready && in_stall)
        else $error("register write did not start a setup");

    // No item word is taken while the partition is being set up.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> in_stall)
        else $error("item accepted during setup");

    // A failed operation never returns a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |-> (out_data.popped_value == '0))
        else $error("failed operation returned a word");

    // A fresh result comes from an accepted item, via the s1 stage and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result word without an accepted item");

endmodule

bind partitioned_multi_stack pms_checker u_pms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

// File: sim/partitioned_multi_stack_tb.sv
// Self-checking bench for the partitioned multi-stack: directed corner words, then random
// phases under random register settings. Depends on pms_pkg and partitioned_multi_stack.
`timescale 1ns / 1ps

module partitioned_multi_stack_tb;

    import pms_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on any channel
    localparam int SQUEEZE_CYCLES = 200;   // one long hold-off on the result side
    localparam int DRAIN_CYCLES   = 8;     // settling time after the last result
    localparam int RANDOM_OPS     = 1625;
    localparam int REPORT_LIMIT   = 10;

    // Indexes with no register behind them; a write there must leave the stacks alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Mirror of the block: register copies, fill pointers, the word store, and the
    // replies that the operations seen so far are owed, oldest first.
    class stack_mirror;
        logic [USED_W-1:0]  size_reg;
        logic [COUNT_W-1:0] count_reg;
        logic [SIZE_W-1:0]  tops [MAX_STACKS];
        logic [DATA_W-1:0]  words [STORE_DEPTH];
        result_t            owed_replies [$];
        int unsigned        faults;

        function new();
            size_reg  = USED_W'(STORE_DEPTH);
            count_reg = COUNT_W'(1);
            faults    = 0;
            foreach (words[i])
            begin
                words[i] = '0;
            end
            repartition();
        endfunction

        // Out-of-range settings are clamped, not rejected.
        function int unsigned live_size();
            int unsigned s;
            s = size_reg;
            if (s < 1) s = 1;
            if (s > STORE_DEPTH) s = STORE_DEPTH;
            return s;
        endfunction

        function int unsigned live_stacks();
            int unsigned c;
            c = count_reg;
            if (c < 1) c = 1;
            if (c > MAX_STACKS) c = MAX_STACKS;
            return c;
        endfunction

        function int unsigned region_base(int unsigned j);
            return (live_size() / live_stacks()) * j;
        endfunction

        // The last region also takes whatever the division leaves over.
        function int unsigned region_end(int unsigned j);
            if (j + 1 >= live_stacks()) return live_size();
            return region_base(j + 1);
        endfunction

        function void repartition();
            for (int j = 0; j < MAX_STACKS; j++)
            begin
                tops[j] = (j < live_stacks()) ? SIZE_W'(region_base(j)) : '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_USED_SIZE)
            begin
                size_reg = data[USED_W-1:0];
                repartition();
            end
            else if (idx == CFG_STACK_COUNT)
            begin
                count_reg = data[COUNT_W-1:0];
                repartition();
            end
        endfunction

        function int unsigned pending();
            return owed_replies.size();
        endfunction

        // Called for every item word the block accepts.
        function void note_op(item_t op);
            result_t     r;
            int unsigned sidx;
            int unsigned p;
            r.status       = ST_OK;
            r.popped_value = '0;
            sidx           = op.stack_index;
            p              = (sidx < MAX_STACKS) ? tops[sidx] : 0;
            if (sidx >= live_stacks())
            begin
                r.status = ST_BAD_INDEX;
            end
            else if (op.action == ACT_PUSH)
            begin
                if (p >= region_end(sidx))
                    r.status = ST_OVERFLOW;
                else
                begin
                    words[p]   = op.item_value;
                    tops[sidx] = SIZE_W'(p + 1);
                end
            end
            else
            begin
                if (p <= region_base(sidx))
                    r.status = ST_UNDERFLOW;
                else
                begin
                    r.popped_value = words[p - 1];
                    tops[sidx]     = SIZE_W'(p - 1);
                end
            end
            owed_replies.push_back(r);
        endfunction

        // Called for every result word the bench accepts.
        function void check_reply(result_t got);
            result_t want;
            if (owed_replies.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("ERROR: unexpected result word, status %0d value %0d",
                             got.status, got.popped_value);
                return;
            end
            want = owed_replies.pop_front();
            if (got.status !== want.status)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("ERROR: status expected %0d, got %0d", want.status, got.status);
            end
            if (got.popped_value !== want.popped_value)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("ERROR: popped value expected %0d, got %0d",
                             want.popped_value, got.popped_value);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    item_t                 in_data;
    logic                  out_valid;
    logic                  out_stall;
    result_t               out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    stack_mirror board = new();
    item_t       batch [$];
    bit          squeeze_req  = 1'b0;
    bit          squeeze_done = 1'b0;

    partitioned_multi_stack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic item_t make_op(action_t act, int unsigned sidx,
                                      logic [DATA_W-1:0] value);
        item_t op;
        op.action      = act;
        op.stack_index = IDX_W'(sidx);
        op.item_value  = value;
        return op;
    endfunction

    // Register writes wait until every owed result has come back, so the block is idle.
    // cfg_valid stays high between back-to-back writes and drops after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                             input bit last);
        while (board.pending() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, data);
        if (last) cfg_valid <= 1'b0;
    endtask

    // Offers the queued item words in order. Gaps are mostly short with the odd long one;
    // a tight batch offers a word on every cycle.
    task automatic send_batch(input bit tight);
        item_t       op;
        int unsigned gap;
        int unsigned roll;
        while (batch.size() != 0)
        begin
            op   = batch.pop_front();
            roll = $urandom_range(0, 99);
            if (tight || roll < 55)
                gap = 0;
            else if (roll < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(4, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= op;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            board.note_op(op);
        end
        in_valid <= 1'b0;
    endtask

    // Result side: checks each accepted word and stalls at random. Once asked, it holds
    // off for a long stretch so that the block backs up and stalls its input.
    initial
    begin
        int unsigned stall_left;
        int unsigned calm;
        int unsigned roll;
        stall_left = 0;
        calm       = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_reply(out_data);
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            if (calm != 0)
            begin
                calm--;
                stall_left = 0;
            end
            else if (stall_left == 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    calm = $urandom_range(50, 200);
                else if (roll >= 92)
                    stall_left = $urandom_range(4, 40);
                else if (roll >= 65)
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Ends the run if no word moves on any channel for too long.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        item_t            op;
        logic [CFG_W-1:0] size_word;
        logic [CFG_W-1:0] count_word;
        int unsigned      done_ops;
        int unsigned      phase;
        int unsigned      n_ops;
        int unsigned      bias;
        bit               tight;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_USED_SIZE;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset layout, one stack over the whole store: empty pop, unused stack,
        // extreme values pushed and popped back in reverse order.
        batch.push_back(make_op(ACT_POP, 0, 32'h0));
        batch.push_back(make_op(ACT_PUSH, 1, 32'h1));
        batch.push_back(make_op(ACT_PUSH, 0, 32'h7FFF_FFFF));
        batch.push_back(make_op(ACT_PUSH, 0, 32'h8000_0000));
        batch.push_back(make_op(ACT_POP, 0, 32'hFFFF_FFFF));
        batch.push_back(make_op(ACT_POP, 0, 32'h0));
        batch.push_back(make_op(ACT_POP, 0, 32'h0));
        send_batch(1'b0);

        // Fewer words than stacks: all regions but the last are empty.
        write_reg(CFG_USED_SIZE, 11'd2, 1'b0);
        write_reg(CFG_STACK_COUNT, 11'd4, 1'b1);
        batch.push_back(make_op(ACT_PUSH, 0, 32'h5555_5555));
        batch.push_back(make_op(ACT_POP, 2, 32'h0));
        batch.push_back(make_op(ACT_PUSH, 3, 32'hFFFF_FFFF));
        batch.push_back(make_op(ACT_PUSH, 3, 32'h0));
        batch.push_back(make_op(ACT_PUSH, 3, 32'h5));
        batch.push_back(make_op(ACT_POP, 3, 32'h0));
        batch.push_back(make_op(ACT_PUSH, 4, 32'h1));
        batch.push_back(make_op(ACT_POP, 7, 32'h0));
        send_batch(1'b1);

        // Zero settings act as one word and one stack; the count write carries junk above
        // its four bits.
        write_reg(CFG_USED_SIZE, 11'd0, 1'b0);
        write_reg(CFG_STACK_COUNT, 11'h7F0, 1'b1);
        batch.push_back(make_op(ACT_PUSH, 0, 32'hA5A5_A5A5));
        batch.push_back(make_op(ACT_PUSH, 0, 32'h5A5A_5A5A));
        batch.push_back(make_op(ACT_POP, 0, 32'h0));
        batch.push_back(make_op(ACT_POP, 1, 32'h0));
        send_batch(1'b0);

        // Oversized settings clamp to the whole store and eight stacks. A word left on
        // stack 7 must survive writes to the spare indexes.
        write_reg(CFG_USED_SIZE, 11'h7FF, 1'b0);
        write_reg(CFG_STACK_COUNT, 11'h00F, 1'b1);
        batch.push_back(make_op(ACT_PUSH, 7, 32'h1234_5678));
        send_batch(1'b0);
        write_reg(CFG_SPARE_LO, 11'h7FF, 1'b0);
        write_reg(CFG_SPARE_HI, 11'h000, 1'b1);
        batch.push_back(make_op(ACT_POP, 7, 32'h0));
        batch.push_back(make_op(ACT_PUSH, 6, 32'hDEAD_BEEF));
        batch.push_back(make_op(ACT_POP, 6, 32'h0));
        send_batch(1'b0);

        // Random phases: each picks a layout, a push/pop balance and an idling style.
        // Small stores dominate so that stacks fill and empty often.
        done_ops = 0;
        phase    = 0;
        while (done_ops < RANDOM_OPS)
        begin
            case ($urandom_range(0, 7))
                0: size_word = CFG_W'(STORE_DEPTH);
                1: size_word = CFG_W'($urandom_range(STORE_DEPTH + 1, (1 << USED_W) - 1));
                2: size_word = CFG_W'($urandom_range(0, 3));
                default: size_word = CFG_W'($urandom_range(1, 48));
            endcase
            count_word = CFG_W'($urandom);
            if ($urandom_range(0, 3) == 0)
                count_word[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 15));
            else
                count_word[COUNT_W-1:0] = COUNT_W'($urandom_range(1, MAX_STACKS));
            if ($urandom_range(0, 9) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          CFG_W'($urandom), 1'b0);
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(CFG_USED_SIZE, size_word, 1'b0);
                write_reg(CFG_STACK_COUNT, count_word, 1'b1);
            end
            else
            begin
                write_reg(CFG_STACK_COUNT, count_word, 1'b0);
                write_reg(CFG_USED_SIZE, size_word, 1'b1);
            end

            n_ops = $urandom_range(60, 200);
            bias  = $urandom_range(25, 75);
            tight = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n_ops; k++)
            begin
                op.action = ($urandom_range(0, 99) < bias) ? ACT_PUSH : ACT_POP;
                if ($urandom_range(0, 4) == 0)
                    op.stack_index = IDX_W'($urandom_range(0, MAX_STACKS - 1));
                else
                    op.stack_index = IDX_W'($urandom_range(0, board.live_stacks() - 1));
                op.item_value = $urandom;
                batch.push_back(op);
            end
            // The second phase is where the result side backs the block up.
            if (phase == 1)
                squeeze_req = 1'b1;
            send_batch(tight);
            done_ops += n_ops;
            phase++;
        end

        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.faults == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/pms_pkg.sv
rtl/pms_word_ram.sv
rtl/pms_setup.sv
rtl/pms_engine.sv
rtl/partitioned_multi_stack.sv
rtl/pms_checker.sv
sim/partitioned_multi_stack_tb.sv
